// ===== sv/sfc_pkg.sv =====
// Shared types and constants for the sphere-against-frustum culling test.
// Used by sfc_plane_eval, the top level and the port checker. No dependencies.
`default_nettype none

package sfc_pkg;

  localparam int NUM_PLANES  = 6;
  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int PROD_W      = 2 * VALUE_WIDTH;
  // Three products plus the shifted offset need two bits of headroom.
  localparam int SUM_W       = PROD_W + 2;
  localparam int COUNT_W     = 32;
  localparam int CMD_W       = 2;
  localparam int SLOT_W      = 3;

  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TEST  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic        [CMD_W-1:0]       command;
    logic        [SLOT_W-1:0]      plane_slot;
    logic signed [VALUE_WIDTH-1:0] coef_a;
    logic signed [VALUE_WIDTH-1:0] coef_b;
    logic signed [VALUE_WIDTH-1:0] coef_c;
    logic signed [VALUE_WIDTH-1:0] coef_d;
    logic signed [VALUE_WIDTH-1:0] center_x;
    logic signed [VALUE_WIDTH-1:0] center_y;
    logic signed [VALUE_WIDTH-1:0] center_z;
    logic        [VALUE_WIDTH-2:0] sphere_radius;
  } item_t;

  typedef struct packed {
    logic               visible;
    logic [COUNT_W-1:0] culled_total;
    logic [COUNT_W-1:0] drawn_total;
  } result_t;

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] a;
    logic signed [VALUE_WIDTH-1:0] b;
    logic signed [VALUE_WIDTH-1:0] c;
    logic signed [VALUE_WIDTH-1:0] d;
  } plane_t;

  // Load enables for the two pipeline stages inside each plane evaluator.
  typedef struct packed {
    logic load_prod;
    logic load_sign;
  } eval_en_t;

endpackage

`default_nettype wire

// ===== sv/sfc_plane_eval.sv =====
// Signed distance of a sphere against one plane, two register stages deep.
// Depends on sfc_pkg for the plane type, widths and stage enables.
`default_nettype none

module sfc_plane_eval import sfc_pkg::*; (
  input  logic                          clk,
  input  eval_en_t                      en,
  input  plane_t                        plane,
  input  logic signed [VALUE_WIDTH-1:0] center_x,
  input  logic signed [VALUE_WIDTH-1:0] center_y,
  input  logic signed [VALUE_WIDTH-1:0] center_z,
  input  logic        [VALUE_WIDTH-2:0] sphere_radius,
  output logic                          behind
);

  logic signed [PROD_W-1:0]    prod_a, prod_b, prod_c;
  logic signed [PROD_W-1:0]    prod_a_next, prod_b_next, prod_c_next;
  logic signed [VALUE_WIDTH:0] offset, offset_next;
  logic signed [SUM_W-1:0]     plane_distance;

  assign prod_a_next = plane.a * center_x;
  assign prod_b_next = plane.b * center_y;
  assign prod_c_next = plane.c * center_z;
  // d + r: the radius moves the plane outward, so the test is against zero.
  assign offset_next = $signed({plane.d[VALUE_WIDTH-1], plane.d})
                     + $signed({2'b00, sphere_radius});

  // The offset carries FRAC_BITS fraction bits; the products carry twice that.
  assign plane_distance = SUM_W'(prod_a) + SUM_W'(prod_b) + SUM_W'(prod_c)
                        + (SUM_W'(offset) <<< FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en.load_prod) begin
      prod_a <= prod_a_next;
      prod_b <= prod_b_next;
      prod_c <= prod_c_next;
      offset <= offset_next;
    end
    if (en.load_sign) begin
      behind <= plane_distance[SUM_W-1];
    end
  end

endmodule

`default_nettype wire

// ===== sv/sphere_frustum_cull_test_top.sv =====
// Sphere against six-plane view frustum culling test.
// A result is registered at the output after its item passes the input, product and sign stages.
// Throughput: one item per cycle while result_stall is low; the stages advance independently.
// Reset (rst, synchronous): plane table and both counters cleared to zero.
// Reset also empties every stage; nothing is in flight afterward.
// Depends on sfc_pkg and sfc_plane_eval.
`default_nettype none

module sphere_frustum_cull_test_top import sfc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_stall,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  // Pipeline layout:
  //   stage 1  input register; a load item writes the plane table as it leaves.
  //   stage 2  one 32x32 multiply for each of a, b and c per plane, registered.
  //   stage 3  four-term sum per plane, only its sign is kept.
  //   output   counters update and the result register is loaded.
  // A test item reads the table while it sits in stage 1. Items leave stage 1
  // in order, so every earlier load has already written its entry by then.

  item_t            item_q;
  logic             valid1, valid2, valid3;
  logic [CMD_W-1:0] cmd2, cmd3;

  logic ready1, ready2, ready3, ready4;
  logic adv2, adv3, adv4;

  plane_t              plane_table [NUM_PLANES];
  logic [NUM_PLANES-1:0] behind;
  eval_en_t            eval_en;

  logic [COUNT_W-1:0] culled_count, drawn_count;
  logic [COUNT_W-1:0] culled_count_next, drawn_count_next;
  logic               visible_next;
  logic               cull;

  // A stage may load when it is empty or when its content moves on.
  assign ready4 = !result_valid || !result_stall;
  assign ready3 = !valid3 || ready4;
  assign ready2 = !valid2 || ready3;
  assign ready1 = !valid1 || ready2;
  assign adv2   = valid1 && ready2;
  assign adv3   = valid2 && ready3;
  assign adv4   = valid3 && ready4;

  assign item_stall = !ready1;

  assign eval_en.load_prod = adv2;
  assign eval_en.load_sign = adv3;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1       <= 1'b0;
      valid2       <= 1'b0;
      valid3       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (item_valid && ready1) begin
        valid1 <= 1'b1;
      end else if (adv2) begin
        valid1 <= 1'b0;
      end
      if (adv2) begin
        valid2 <= 1'b1;
      end else if (adv3) begin
        valid2 <= 1'b0;
      end
      if (adv3) begin
        valid3 <= 1'b1;
      end else if (adv4) begin
        valid3 <= 1'b0;
      end
      if (adv4) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers along the pipe carry no reset.
  always_ff @(posedge clk) begin
    if (item_valid && ready1) begin
      item_q <= item;
    end
    if (adv2) begin
      cmd2 <= item_q.command;
    end
    if (adv3) begin
      cmd3 <= cmd2;
    end
    if (adv4) begin
      result.visible      <= visible_next;
      result.culled_total <= culled_count_next;
      result.drawn_total  <= drawn_count_next;
    end
  end

  // Plane table: a slot beyond the table matches no entry and is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        plane_table[i] <= '0;
      end
    end else if (adv2 && item_q.command == CMD_LOAD) begin
      for (int i = 0; i < NUM_PLANES; i++) begin
        if (item_q.plane_slot == SLOT_W'(i)) begin
          plane_table[i].a <= item_q.coef_a;
          plane_table[i].b <= item_q.coef_b;
          plane_table[i].c <= item_q.coef_c;
          plane_table[i].d <= item_q.coef_d;
        end
      end
    end
  end

  // One evaluator per plane; all six tests run side by side.
  for (genvar g = 0; g < NUM_PLANES; g++) begin : g_plane
    sfc_plane_eval u_eval (
      .clk          (clk),
      .en           (eval_en),
      .plane        (plane_table[g]),
      .center_x     (item_q.center_x),
      .center_y     (item_q.center_y),
      .center_z     (item_q.center_z),
      .sphere_radius(item_q.sphere_radius),
      .behind       (behind[g])
    );
  end

  // The sphere is culled when it lies fully behind any one plane.
  assign cull = |behind;

  always_comb begin
    culled_count_next = culled_count;
    drawn_count_next  = drawn_count;
    visible_next      = 1'b0;
    case (cmd3)
      CMD_TEST: begin
        if (cull) begin
          if (culled_count != COUNT_MAX) begin
            culled_count_next = culled_count + COUNT_W'(1);
          end
        end else begin
          visible_next = 1'b1;
          if (drawn_count != COUNT_MAX) begin
            drawn_count_next = drawn_count + COUNT_W'(1);
          end
        end
      end
      CMD_CLEAR: begin
        culled_count_next = '0;
        drawn_count_next  = '0;
      end
      default: begin
        // Loads and the unused code leave both counters as they are.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      culled_count <= '0;
      drawn_count  <= '0;
    end else if (adv4) begin
      culled_count <= culled_count_next;
      drawn_count  <= drawn_count_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/sfc_checker.sv =====
// Port-level checks for the culling test, bound to the top level.
// Depends on sfc_pkg for the result type.
`default_nettype none

module sfc_checker import sfc_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_stall,
  input result_t result
);

  // No result may appear in the cycle after reset.
  assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // A stalled result stays and does not change.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result changed or dropped");

  // A drawn sphere has always been counted.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result.visible |-> result.drawn_total != '0)
    else $error("visible result with zero drawn count");

  // Between back-to-back results the counters only grow, unless cleared.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid
      || (result.culled_total == '0 && result.drawn_total == '0)
      || (result.culled_total >= $past(result.culled_total)
          && result.drawn_total >= $past(result.drawn_total)))
    else $error("counter went backward without a clear");

endmodule

bind sphere_frustum_cull_test_top sfc_checker u_sfc_checker (.*);

`default_nettype wire
